/* rtl/tlep_pkg.sv */
// ----------------------------------------------------------------------------
// tlep_pkg
// shared types and constants of the terminal line and escape parser
// ----------------------------------------------------------------------------
package tlep_pkg;

  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LINE_DEPTH + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DATA_W  = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2,
    KIND_KEY  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO,
    ST_SCAN_START,
    ST_SCAN,
    ST_KEY,
    ST_CR,
    ST_LF,
    ST_DUMP,
    ST_END
  } state_e;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'd27;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;

  localparam logic [CODE_W-1:0]  KEY_FUNC      = 3'd4;
  localparam logic [COUNT_W-1:0] CURSOR_DEFAULT = 16'd1;
  localparam logic [COUNT_W-1:0] FUNC_DEFAULT   = 16'd255;

endpackage

/* rtl/tlep_ram.sv */
// ----------------------------------------------------------------------------
// tlep_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tlep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/terminal_line_and_escape_parser_core.sv */
// ----------------------------------------------------------------------------
// terminal_line_and_escape_parser_core
// line editor and escape sequence decoder for received terminal bytes
//
//   channel   dir  tdata                                         tuser  tlast
//   s_axis    in   [7:0] rx_byte                                 -      -
//   m_axis    out  [7:0] out_byte, [13:8] line_length,           kind   last
//                  [16:14] key_code, [32:17] key_count
//
// a byte that only echoes passes from the echo state into the output register
// a printable byte in escape mode scans the line ram one entry per cycle
// and hands a decoded key sequence to the key state
// a line end streams the line at one character per cycle off the ram read port
// while the output is not stalled
// output stalls hold the sequencer; reset clears state, length, escape mode and output valid only
// ----------------------------------------------------------------------------
module terminal_line_and_escape_parser_core
  import tlep_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // out_byte, line_length, key_code,
                                            // key_count, zero fill
  output logic [KIND_W-1:0] m_axis_tuser,   // [1:0] kind
  output logic              m_axis_tlast
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 esc_q, esc_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [COUNT_W-1:0]   val_q, val_d;
  logic [CODE_W-1:0]    code_q, code_d;
  logic [COUNT_W-1:0]   kcnt_q, kcnt_d;
  logic [BYTE_W-1:0]    echo_q, echo_d;

  logic                 o_vld_q;
  kind_e                o_kind_q;
  logic [BYTE_W-1:0]    o_byte_q;
  logic [LEN_W-1:0]     o_len_q;
  logic [CODE_W-1:0]    o_code_q;
  logic [COUNT_W-1:0]   o_count_q;
  logic                 o_last_q;

  logic                 ld;
  kind_e                ld_kind;
  logic [BYTE_W-1:0]    ld_byte;
  logic [LEN_W-1:0]     ld_len;
  logic [CODE_W-1:0]    ld_code;
  logic [COUNT_W-1:0]   ld_count;
  logic                 ld_last;

  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;
  logic                 out_free;
  logic                 in_req;
  logic [CNT_W-1:0]     idx_ext;
  logic [COUNT_W-1:0]   val_x10;

  tlep_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free      = !o_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign idx_ext       = CNT_W'(idx_q);
  assign val_x10       = {val_q[COUNT_W-4:0], 3'b000} + {val_q[COUNT_W-2:0], 1'b0};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    esc_d     = esc_q;
    idx_d     = idx_q;
    val_d     = val_q;
    code_d    = code_q;
    kcnt_d    = kcnt_q;
    echo_d    = echo_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q + IDX_W'(1);
    ld        = 1'b0;
    ld_kind   = KIND_ECHO;
    ld_byte   = '0;
    ld_len    = '0;
    ld_code   = '0;
    ld_count  = '0;
    ld_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          if (s_axis_tdata inside {[CH_SPACE:CH_TILDE]}) begin
            if (cnt_q < CNT_W'(LINE_DEPTH)) begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
            if (esc_q) begin
              state_d = ST_SCAN_START;
            end else begin
              echo_d  = s_axis_tdata;
              state_d = ST_ECHO;
            end
          end else if (s_axis_tdata == CH_DEL) begin
            if (cnt_q != '0) begin
              cnt_d   = cnt_q - CNT_W'(1);
              echo_d  = CH_DEL;
              state_d = ST_ECHO;
            end
          end else if (s_axis_tdata == CH_CR || s_axis_tdata == CH_LF) begin
            state_d = ST_CR;
          end else if (s_axis_tdata == CH_ESC) begin
            cnt_d = '0;
            esc_d = 1'b1;
          end
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_byte = echo_q;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_START: begin
        if (cnt_q < CNT_W'(2)) begin
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          idx_d     = '0;
          val_d     = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == '0) begin
          if (ram_rdata == CH_LBRK) begin
            ram_re = 1'b1;
            idx_d  = idx_q + IDX_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end else if (idx_ext != cnt_q - CNT_W'(1)) begin
          if (ram_rdata inside {[CH_0:CH_9]}) begin
            val_d  = val_x10 + COUNT_W'(ram_rdata[3:0]);
            ram_re = 1'b1;
            idx_d  = idx_q + IDX_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end else if (ram_rdata inside {[CH_A:CH_D]}) begin
          code_d  = ram_rdata[CODE_W-1:0] - CH_A[CODE_W-1:0];
          kcnt_d  = (cnt_q > CNT_W'(2)) ? val_q : CURSOR_DEFAULT;
          state_d = ST_KEY;
        end else if (ram_rdata == CH_TILDE) begin
          code_d  = KEY_FUNC;
          kcnt_d  = (cnt_q > CNT_W'(2)) ? val_q : FUNC_DEFAULT;
          state_d = ST_KEY;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_KEY: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = KIND_KEY;
          ld_code  = code_q;
          ld_count = kcnt_q;
          ld_last  = 1'b1;
          cnt_d    = '0;
          esc_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      ST_CR: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_byte = CH_CR;
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_byte = CH_LF;
          if (cnt_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = ST_DUMP;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = KIND_CHAR;
          ld_byte = ram_rdata;
          if (idx_ext + CNT_W'(1) < cnt_q) begin
            ram_re = 1'b1;
            idx_d  = idx_q + IDX_W'(1);
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = KIND_END;
          ld_len  = LEN_W'(cnt_q);
          ld_last = 1'b1;
          cnt_d   = '0;
          esc_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      esc_q   <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      esc_q   <= esc_d;
      if (ld) begin
        o_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    code_q <= code_d;
    kcnt_q <= kcnt_d;
    echo_q <= echo_d;
    if (ld) begin
      o_kind_q  <= ld_kind;
      o_byte_q  <= ld_byte;
      o_len_q   <= ld_len;
      o_code_q  <= ld_code;
      o_count_q <= ld_count;
      o_last_q  <= ld_last;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {7'b0, o_count_q, o_code_q, o_len_q, o_byte_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LINE_DEPTH))
    else $error("line length beyond line depth");

  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> idx_ext < cnt_q)
    else $error("dump index past line end");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line ram read and write in one cycle");

  a_esc_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req && s_axis_tdata == CH_ESC |=> cnt_q == '0 && esc_q)
    else $error("escape byte did not clear line and enter escape mode");

  a_no_load_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> out_free)
    else $error("result loaded over a pending result");

endmodule

/* tb/sv/terminal_line_and_escape_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// terminal_line_and_escape_parser_core_tb
// self-checking bench for the terminal line and escape parser: a scoreboard
// tracks the line buffer and escape mode from every accepted request, predicts
// echoes, line dumps and key events, and checks each output beat in order
// while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module terminal_line_and_escape_parser_core_tb;
  import tlep_pkg::*;

  typedef struct {
    kind_e              kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [LEN_W-1:0]   line_length;
    logic [CODE_W-1:0]  key_code;
    logic [COUNT_W-1:0] key_count;
    logic               last;
  } term_event_t;

  localparam logic [BYTE_W-1:0] OPENING [25] = '{
    CH_SPACE, CH_TILDE, CH_DEL, CH_DEL, CH_DEL, CH_CR, 8'h71, CH_LF,
    CH_ESC, CH_LBRK, CH_A, CH_ESC, CH_LBRK, 8'h37, CH_TILDE,
    CH_ESC, CH_LBRK, CH_TILDE, 8'h00, 8'hFF, 8'h80,
    CH_ESC, 8'h7A, CH_DEL, CH_CR
  };

  class line_event_scoreboard;
    logic [BYTE_W-1:0] line_text [LINE_DEPTH];
    int unsigned       line_len;
    bit                in_escape;
    term_event_t       awaited_outputs [$];
    int unsigned       errors;
    int unsigned       outputs_seen;
    int unsigned       lines_seen;
    int unsigned       keys_seen;
    int unsigned       requests_seen;

    function new();
      line_len  = 0;
      in_escape = 1'b0;
      errors    = 0;
      outputs_seen = 0;
      lines_seen   = 0;
      keys_seen    = 0;
      requests_seen = 0;
    endfunction

    function void add_output(kind_e kind, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len,
                             logic [CODE_W-1:0] code, logic [COUNT_W-1:0] cnt);
      term_event_t ev;
      ev.kind        = kind;
      ev.out_byte    = b;
      ev.line_length = len;
      ev.key_code    = code;
      ev.key_count   = cnt;
      ev.last        = 1'b0;
      awaited_outputs.push_back(ev);
    endfunction

    // '[' digits* then A..D or '~'
    function bit decode_key(output logic [CODE_W-1:0] code, output logic [COUNT_W-1:0] cnt);
      int unsigned idx;
      int unsigned value;
      bit          has_digits;
      logic [BYTE_W-1:0] c;
      code = '0;
      cnt  = '0;
      if (line_len < 2 || line_text[0] != CH_LBRK) return 1'b0;
      idx = 1;
      value = 0;
      has_digits = 1'b0;
      while (idx < line_len && line_text[idx] >= CH_0 && line_text[idx] <= CH_9) begin
        value = (value * 10 + (line_text[idx] - CH_0)) & 32'hFFFF;
        has_digits = 1'b1;
        idx++;
      end
      if (idx + 1 != line_len) return 1'b0;
      c = line_text[idx];
      if (c >= CH_A && c <= CH_D) begin
        code = CODE_W'(c - CH_A);
        cnt  = has_digits ? COUNT_W'(value) : CURSOR_DEFAULT;
        return 1'b1;
      end
      if (c == CH_TILDE) begin
        code = KEY_FUNC;
        cnt  = has_digits ? COUNT_W'(value) : FUNC_DEFAULT;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void accept_rx_byte(logic [BYTE_W-1:0] b);
      int unsigned        first_new;
      logic [CODE_W-1:0]  code;
      logic [COUNT_W-1:0] cnt;
      first_new = awaited_outputs.size();
      requests_seen++;
      if (b >= CH_SPACE && b <= CH_TILDE) begin
        if (line_len < LINE_DEPTH) begin
          line_text[line_len] = b;
          line_len++;
        end
        if (in_escape) begin
          if (decode_key(code, cnt)) begin
            add_output(KIND_KEY, '0, '0, code, cnt);
            line_len  = 0;
            in_escape = 1'b0;
          end
        end else begin
          add_output(KIND_ECHO, b, '0, '0, '0);
        end
      end else if (b == CH_DEL) begin
        if (line_len > 0) begin
          line_len--;
          add_output(KIND_ECHO, CH_DEL, '0, '0, '0);
        end
      end else if (b == CH_CR || b == CH_LF) begin
        add_output(KIND_ECHO, CH_CR, '0, '0, '0);
        add_output(KIND_ECHO, CH_LF, '0, '0, '0);
        for (int i = 0; i < line_len; i++) add_output(KIND_CHAR, line_text[i], '0, '0, '0);
        add_output(KIND_END, '0, LEN_W'(line_len), '0, '0);
        line_len  = 0;
        in_escape = 1'b0;
      end else if (b == CH_ESC) begin
        line_len  = 0;
        in_escape = 1'b1;
      end
      if (awaited_outputs.size() > first_new)
        awaited_outputs[awaited_outputs.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_output(logic [KIND_W-1:0] user, logic [DATA_W-1:0] data, logic tlast);
      term_event_t ev;
      outputs_seen++;
      if (awaited_outputs.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected output, expected none actual kind %0d data 0x%0h",
                   $time, user, data);
        return;
      end
      ev = awaited_outputs.pop_front();
      if (ev.kind == KIND_END) lines_seen++;
      if (ev.kind == KIND_KEY) keys_seen++;
      compare_field("kind", ev.kind, user);
      compare_field("out_byte", ev.out_byte, data[7:0]);
      compare_field("line_length", ev.line_length, data[13:8]);
      compare_field("key_code", ev.key_code, data[16:14]);
      compare_field("key_count", ev.key_count, data[32:17]);
      compare_field("zero fill", 0, data[DATA_W-1:33]);
      compare_field("last", ev.last, tlast);
    endfunction

    function int unsigned outstanding();
      return awaited_outputs.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  line_event_scoreboard sb;
  bit          stress_go;
  int unsigned burst_left;
  int unsigned sent_count;

  terminal_line_and_escape_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.accept_rx_byte(s_axis_tdata);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  // receiver: random stall modes, plus one long hold-off once random traffic starts
  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && stress_go) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (k % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    logic [7:0]  fin;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stress_go     = 1'b0;
    burst_left    = 0;
    sent_count    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPENING[i]) send_byte(OPENING[i]);

    stress_go = 1'b1;
    // overfull line
    for (int i = 0; i < 36; i++) send_byte(8'($urandom_range(32, 126)));
    send_byte(CH_LF);

    while (sent_count < 360) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) send_byte(CH_DEL);
          else send_byte(8'($urandom_range(32, 126)));
        end
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (pick < 75) begin
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          send_byte(CH_0 + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 12) == 0) send_byte(CH_DEL);
        end
        fin = 8'($urandom_range(0, 4));
        send_byte(fin == 4 ? CH_TILDE : CH_A + fin);
      end else if (pick < 88) begin
        send_byte(CH_ESC);
        if ($urandom_range(0, 5) == 0) begin
          send_byte(CH_LBRK);
          for (int i = 0; i < 35; i++) send_byte(CH_0 + 8'($urandom_range(0, 9)));
          send_byte(CH_A + 8'($urandom_range(0, 3)));
        end else begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 1)) send_byte(CH_CR);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("run covered %0d requests and %0d output beats", sb.requests_seen, sb.outputs_seen);
    $display("completed lines %0d, key events %0d, mismatches %0d",
             sb.lines_seen, sb.keys_seen, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[terminal_line_and_escape_parser_core] OK");
    end else begin
      $display("[terminal_line_and_escape_parser_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d outputs still awaited", sb.outstanding());
    $display("[terminal_line_and_escape_parser_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tlep_pkg.sv
rtl/tlep_ram.sv
rtl/terminal_line_and_escape_parser_core.sv
tb/sv/terminal_line_and_escape_parser_core_tb.sv
